### hw/rtl/deque_with_positional_access_assert.svh
// Assertion macros shared by the deque block.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef DEQUE_WITH_POSITIONAL_ACCESS_ASSERT_SVH
`define DEQUE_WITH_POSITIONAL_ACCESS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DQPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DQPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/dqpa_pkg.sv
// Shared sizes, codes and structs of the deque block.
// Used by the controller, the entry RAM hookup and the top level.
package dqpa_pkg;

  // DEPTH must be a power of two: ring slots wrap by truncation.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = 5;
  localparam int CMD_W      = 3;
  localparam int VAL_W      = 32;
  localparam int POS_W      = 5;
  localparam int ST_W       = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REMOVE_AT  = 3'd4,
    CMD_READ_AT    = 3'd5
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // One result word as it leaves the controller.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    status_t          status;
    logic [CNT_W-1:0] count;
  } res_t;

  // Port requests from the controller to the entry RAM.
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } ram_req_t;

endpackage

### hw/rtl/dqpa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependency.
module dqpa_ram #(
  parameter int DW = 32,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/dqpa_ctrl.sv
// Command sequencer of the deque: front index, count and RAM access control.
// Depends on dqpa_pkg; drives the entry RAM through a ram_req_t struct.
module dqpa_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dqpa_pkg::CMD_W-1:0]      in_cmd,
  input  logic [dqpa_pkg::VAL_W-1:0]      in_value,
  input  logic [dqpa_pkg::POS_W-1:0]      in_pos,
  input  logic                            out_free,
  output logic                            res_load,
  output dqpa_pkg::res_t                  res,
  output dqpa_pkg::ram_req_t              ram_req,
  input  logic [dqpa_pkg::DATA_WIDTH-1:0] ram_rdata
);
  import dqpa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RDWAIT = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_RESP   = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] front, front_next;
  logic [CNT_W-1:0] occ, occ_next;
  cmd_t             cmd, cmd_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [CNT_W-1:0] off, off_next;
  logic [VAL_W-1:0] rval, rval_next;
  status_t          rst_code, rst_code_next;

  cmd_t             cmd_in;
  logic [CNT_W:0]   off_plus2;

  // Ring slot of the entry at a given offset from the front.
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] f,
                                             input logic [CNT_W-1:0] o);
    slot = f + o[IDX_W-1:0];
  endfunction

  assign cmd_in    = cmd_t'(in_cmd);
  assign off_plus2 = {1'b0, off} + (CNT_W+1)'(2);
  assign in_ready  = (state == S_IDLE);

  // Result seen by the output register.
  assign res.value  = rval;
  assign res.status = rst_code;
  assign res.count  = occ;

  // Next-state and RAM request logic.
  always_comb begin
    state_next    = state;
    front_next    = front;
    occ_next      = occ;
    cmd_next      = cmd;
    pos_next      = pos;
    off_next      = off;
    rval_next     = rval;
    rst_code_next = rst_code;
    ram_req       = '0;
    res_load      = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_next      = cmd_in;
          pos_next      = in_pos;
          rval_next     = '0;
          rst_code_next = ST_OK;
          state_next    = S_RESP;
          case (cmd_in)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
              if (occ == CNT_W'(DEPTH)) begin
                rst_code_next = ST_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.wdata = DATA_WIDTH'(in_value);
                occ_next      = occ + CNT_W'(1);
                if (cmd_in == CMD_PUSH_BACK) begin
                  ram_req.waddr = slot(front, occ);
                end else begin
                  ram_req.waddr = front - IDX_W'(1);
                  front_next    = front - IDX_W'(1);
                end
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (occ == '0) begin
                rst_code_next = ST_EMPTY;
              end else begin
                ram_req.re = 1'b1;
                ram_req.raddr = (cmd_in == CMD_POP_FRONT) ? front
                                                          : slot(front, occ - CNT_W'(1));
                state_next = S_RDWAIT;
              end
            end
            CMD_REMOVE_AT, CMD_READ_AT: begin
              if (occ == '0) begin
                rst_code_next = ST_EMPTY;
              end else if (in_pos == '0 || in_pos > occ) begin
                rst_code_next = ST_RANGE;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = slot(front, CNT_W'(in_pos) - CNT_W'(1));
                state_next    = S_RDWAIT;
              end
            end
            default: begin
              // Unused codes leave the deque contents alone and report ok.
            end
          endcase
        end
      end

      S_RDWAIT: begin
        // The addressed word is now on the read port.
        rval_next  = VAL_W'(ram_rdata);
        state_next = S_RESP;
        case (cmd)
          CMD_POP_FRONT: begin
            front_next = front + IDX_W'(1);
            occ_next   = occ - CNT_W'(1);
          end
          CMD_POP_BACK: begin
            occ_next = occ - CNT_W'(1);
          end
          CMD_REMOVE_AT: begin
            if (CNT_W'(pos) < occ) begin
              // Later entries move up one slot; fetch the first of them.
              ram_req.re    = 1'b1;
              ram_req.raddr = slot(front, CNT_W'(pos));
              off_next      = CNT_W'(pos) - CNT_W'(1);
              state_next    = S_SHIFT;
            end else begin
              occ_next = occ - CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end

      S_SHIFT: begin
        // Write the fetched word one slot forward and fetch the next one.
        ram_req.we    = 1'b1;
        ram_req.waddr = slot(front, off);
        ram_req.wdata = ram_rdata;
        off_next      = off + CNT_W'(1);
        if (off_plus2 < {1'b0, occ}) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = slot(front, off_plus2[CNT_W-1:0]);
        end else begin
          occ_next   = occ - CNT_W'(1);
          state_next = S_RESP;
        end
      end

      S_RESP: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      occ   <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      occ   <= occ_next;
    end
  end

  // Per-command payload registers.
  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    pos      <= pos_next;
    off      <= off_next;
    rval     <= rval_next;
    rst_code <= rst_code_next;
  end

endmodule

### hw/rtl/deque_with_positional_access.sv
// Bounded deque of 16 words of 32 bits kept in a ring in one dual-port RAM.
// Each input word is one command and yields exactly one result word. A push
// or any request that fails its checks goes from acceptance straight to the
// response state, from which its result is loaded into the output register.
// A pop or a read passes through a read-wait state first, since the entry RAM
// read port is registered. Removal at position p with n entries held then
// moves the n - p entries behind the gap forward one word per cycle through
// the single RAM write port. A new command is accepted while the previous
// result still waits at the output register, but a finished result that
// finds that register still full holds the block in its response state
// until the consumer takes the waiting word.
`include "deque_with_positional_access_assert.svh"

module deque_with_positional_access (
  input  logic        clk,
  input  logic        rst,
  // Command stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, lowest bit up: command[2:0], value[34:3], position[39:35].
  input  logic [39:0] s_tdata,
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, lowest bit up: value_res[31:0], status[33:32], count[38:34],
  // zero pad[39].
  output logic [39:0] m_tdata
);
  import dqpa_pkg::*;

  logic                  res_load;
  res_t                  res;
  ram_req_t              ram_req;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                  out_free;
  res_t                  out_res;
  logic                  in_take;
  logic                  out_err;

  assign out_free = !m_tvalid || m_tready;

  // Command sequencer.
  dqpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tdata[2:0]),
    .in_value  (s_tdata[34:3]),
    .in_pos    (s_tdata[39:35]),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // Entry store.
  dqpa_ram #(
    .DW (DATA_WIDTH),
    .AW (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Output register: holds one result word until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign m_tdata = {1'b0, out_res.count, out_res.status, out_res.value};

  // Handshake and error terms watched by the checks below.
  assign in_take = s_tvalid && s_tready;
  assign out_err = m_tvalid && out_res.status != ST_OK;

  // A delivered count never exceeds the capacity.
  `DQPA_ASSERT_NOW(a_count_bound, clk, rst, m_tvalid, out_res.count <= CNT_W'(DEPTH), "bad count")
  // A failed request carries a zero word.
  `DQPA_ASSERT_NOW(a_err_zero, clk, rst, out_err, out_res.value == '0, "word not zero on error")
  // A result is only produced while no new command can be taken.
  `DQPA_ASSERT_NOW(a_busy_load, clk, rst, res_load, !s_tready, "result loaded while idle")
  // Every accepted command makes the block busy in the next cycle.
  `DQPA_ASSERT_NEXT(a_accept_busy, clk, rst, in_take, !s_tready, "ready held after accept")

endmodule
